// ----- hw/rtl/cmm_pkg.sv -----
// Package for the channel mixer with meters: widths, reset values, register codes,
// state machine type and the meter state record. Depends on nothing.
package cmm_pkg;

  localparam int unsigned CHANNELS_DEF   = 4;
  localparam int unsigned MAX_FRAMES_DEF = 1024;
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned SMP_W  = 24;
  localparam int unsigned OUT_W  = 28;
  localparam int unsigned INM_W  = 26;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SUM_W  = 64;

  localparam logic [CIDX_W-1:0] REG_LEFT_GAIN  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_RIGHT_GAIN = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FADER_GAIN = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CHAN_GAINS = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MUTE_MASK  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_SOLO_MASK  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_MASTER_MUTE = 3'd6;

  localparam logic [15:0] LEFT_GAIN_RST  = 16'd11585;
  localparam logic [15:0] FADER_GAIN_RST = 16'd16384;
  localparam logic [63:0] CHAN_GAINS_RST = 64'h4000400040004000;
  localparam logic [27:0] UNITY = 28'h0800000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_DIV, ST_SQRT, ST_DONE
  } state_t;

  // One channel's meter record, held as one memory word.
  typedef struct packed {
    logic [INM_W-1:0] in_peak;
    logic [OUT_W-1:0] out_peak;
    logic [SUM_W-1:0] in_sum;
    logic [SUM_W-1:0] out_sum;
    logic [INM_W-1:0] in_hold;
    logic [OUT_W-1:0] out_hold;
    logic [CNT_W-1:0] count;
  } meter_t;

  typedef struct packed {
    logic [15:0] left_gain;
    logic [15:0] right_gain;
    logic [15:0] fader_gain;
    logic [63:0] chan_gains;
    logic [3:0]  mute;
    logic [3:0]  solo;
    logic        master_mute;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } root_req_t;

  typedef struct packed {
    logic done;
    logic [31:0] root;
  } root_rsp_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// ----- hw/rtl/cmm_if.sv -----
// Valid/ready stream interface used by the testbench for both channels of the mixer.
// Depends on nothing; the payload is a type parameter.
interface cmm_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cmm_cfg.sv -----
// Configuration register file of the mixer.
// Depends on cmm_pkg.
module cmm_cfg (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [cmm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [cmm_pkg::CFG_W-1:0] cfg_wdata,
  output cmm_pkg::cfg_t cfg
);
  cmm_pkg::cfg_t cfg_r;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_gain   <= cmm_pkg::LEFT_GAIN_RST;
      cfg_r.right_gain  <= cmm_pkg::LEFT_GAIN_RST;
      cfg_r.fader_gain  <= cmm_pkg::FADER_GAIN_RST;
      cfg_r.chan_gains  <= cmm_pkg::CHAN_GAINS_RST;
      cfg_r.mute        <= '0;
      cfg_r.solo        <= '0;
      cfg_r.master_mute <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmm_pkg::REG_LEFT_GAIN:   cfg_r.left_gain   <= cfg_wdata[15:0];
        cmm_pkg::REG_RIGHT_GAIN:  cfg_r.right_gain  <= cfg_wdata[15:0];
        cmm_pkg::REG_FADER_GAIN:  cfg_r.fader_gain  <= cfg_wdata[15:0];
        cmm_pkg::REG_CHAN_GAINS:  cfg_r.chan_gains  <= cfg_wdata;
        cmm_pkg::REG_MUTE_MASK:   cfg_r.mute        <= cfg_wdata[3:0];
        cmm_pkg::REG_SOLO_MASK:   cfg_r.solo        <= cfg_wdata[3:0];
        cmm_pkg::REG_MASTER_MUTE: cfg_r.master_mute <= cfg_wdata[0];
        default: ;
      endcase
    end
  end
endmodule

// ----- hw/rtl/cmm_root.sv -----
// Iterative divide then integer square root: floor(sqrt(floor(num/den))).
// One quotient bit, then one root bit, per cycle. Depends on cmm_pkg.
module cmm_root (
  input  logic clk,
  input  logic rst_n,
  input  cmm_pkg::root_req_t req,
  output cmm_pkg::root_rsp_t rsp
);
  logic        busy_r, busy_nxt, phase_r, phase_nxt, done_r, done_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [10:0] den_r, den_nxt;
  logic [31:0] root_r, root_nxt;
  logic [65:0] sh;
  logic [33:0] trial;
  logic [65:0] rem2;

  assign rsp.done = done_r;
  assign rsp.root = root_r;

  always_comb begin
    busy_nxt = busy_r; phase_nxt = phase_r; step_nxt = step_r; q_nxt = q_r;
    rem_nxt = rem_r; den_nxt = den_r; root_nxt = root_r; done_nxt = 1'b0;
    sh = '0; trial = '0; rem2 = '0;
    if (req.start) begin
      busy_nxt = 1'b1; phase_nxt = 1'b0; step_nxt = 6'd63;
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den;
    end else if (busy_r) begin
      if (!phase_r) begin
        // Restoring division: remainder shifts in the next dividend bit.
        sh = {rem_r, q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
        if (sh[64:0] >= {54'd0, den_r}) begin
          rem_nxt = sh[64:0] - {54'd0, den_r};
          q_nxt[0] = 1'b1;
        end else begin
          rem_nxt = sh[64:0];
        end
        if (step_r == 6'd0) begin
          phase_nxt = 1'b1; step_nxt = 6'd31; rem_nxt = '0; root_nxt = '0;
        end else begin
          step_nxt = step_r - 6'd1;
        end
      end else begin
        // Digit-by-digit root: bring down two quotient bits per step.
        rem2 = {rem_r[63:0], q_r[63:62]};
        trial = {root_r, 2'b01};
        q_nxt = {q_r[61:0], 2'b00};
        if (rem2 >= {32'd0, trial}) begin
          rem_nxt = rem2[64:0] - {31'd0, trial};
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem2[64:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        if (step_r == 6'd0) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end else begin
          step_nxt = step_r - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    phase_r <= phase_nxt; step_r <= step_nxt; q_r <= q_nxt;
    rem_r <= rem_nxt; den_r <= den_nxt; root_r <= root_nxt;
  end
endmodule

// ----- hw/rtl/cmm_core.sv -----
// Mixer datapath and sequencer around the per-channel meter memory.
// Depends on cmm_pkg and cmm_root.
module cmm_core #(
  parameter int unsigned CHANNELS   = cmm_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_FRAMES = cmm_pkg::MAX_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmm_pkg::cfg_t cfg,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_chan,
  input  logic signed [23:0] in_sample_in,
  input  logic in_source_present,
  input  logic in_last_frame,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [27:0] out_sample_out,
  output logic [1:0] out_out_chan,
  output logic out_meter_valid,
  output logic [25:0] out_in_peak,
  output logic [25:0] out_in_rms,
  output logic [25:0] out_in_hold,
  output logic [27:0] out_out_peak,
  output logic [27:0] out_out_rms,
  output logic [27:0] out_out_hold,
  output logic out_in_overload,
  output logic out_out_overload
);
  localparam int unsigned CNT_W = cmm_pkg::CNT_W;
  localparam logic [CNT_W-1:0] MAXF = CNT_W'(MAX_FRAMES);

  cmm_pkg::state_t st_r, st_nxt;
  cmm_pkg::meter_t mem [CHANNELS];
  cmm_pkg::meter_t rd_r, wr_m;
  logic            wr_en;

  logic [1:0]  ch_r;
  logic        neg_r, last_r, pres_r, rms_sel_r;
  logic [23:0] mag_r;
  logic [25:0] m1_r;
  logic [27:0] m2_r;
  logic [63:0] in_sum_r, out_sum_r;
  logic [CNT_W-1:0] n_r;
  logic        mval_r;

  logic        ov_r;
  logic signed [27:0] o_smp_r;
  logic [1:0]  o_ch_r;
  logic        o_mv_r;
  logic [25:0] o_ip_r, o_ir_r, o_ih_r;
  logic [27:0] o_op_r, o_or_r, o_oh_r;

  cmm_pkg::root_req_t rreq;
  cmm_pkg::root_rsp_t rrsp;

  logic [15:0] cgain, mgain;
  logic        active;
  logic [39:0] p1;
  logic [41:0] p2;
  cmm_pkg::meter_t m;
  logic [CNT_W-1:0] cnt1;
  logic        ch_ok;

  // Meter state memory: cleared words come from the reset-state pass below.
  logic [2:0] clr_r;
  logic       clr_done_r;

  cmm_root u_root (.clk(clk), .rst_n(rst_n), .req(rreq), .rsp(rrsp));

  assign ch_ok = 32'(in_chan) < CHANNELS;
  assign in_ready = (st_r == cmm_pkg::ST_IDLE) && !ov_r && clr_done_r;

  function automatic logic mval_nxt_f();
    logic [CNT_W-1:0] c;
    c = (rd_r.count <= MAXF) ? rd_r.count + 1'b1 : rd_r.count;
    return last_r && c >= 1 && c <= MAXF;
  endfunction

  always_comb begin
    cgain = cfg.chan_gains[16*ch_r +: 16];
    mgain = (ch_r == 2'd0) ? cfg.left_gain :
            (ch_r == 2'd1) ? cfg.right_gain : cfg.fader_gain;
    active = !cfg.mute[ch_r] && (cfg.solo == 4'd0 || cfg.solo[ch_r]);
    p1 = {16'd0, mag_r} * {24'd0, cgain} + 40'd8192;
    p2 = {16'd0, m1_r} * {26'd0, mgain} + 42'd8192;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      cmm_pkg::ST_IDLE: if (in_valid && in_ready && ch_ok) st_nxt = cmm_pkg::ST_READ;
      cmm_pkg::ST_READ: st_nxt = cmm_pkg::ST_MUL1;
      cmm_pkg::ST_MUL1: st_nxt = cmm_pkg::ST_MUL2;
      cmm_pkg::ST_MUL2: st_nxt = mval_nxt_f() ? cmm_pkg::ST_DIV : cmm_pkg::ST_DONE;
      cmm_pkg::ST_DIV:  st_nxt = cmm_pkg::ST_SQRT;
      cmm_pkg::ST_SQRT: if (rrsp.done)
                          st_nxt = rms_sel_r ? cmm_pkg::ST_DONE : cmm_pkg::ST_DIV;
      cmm_pkg::ST_DONE: st_nxt = cmm_pkg::ST_IDLE;
      default: st_nxt = cmm_pkg::ST_IDLE;
    endcase
  end

  // Read-modify-write of the meter word happens in ST_MUL2, once m2 is known.
  always_comb begin
    m = rd_r;
    cnt1 = (rd_r.count <= MAXF) ? rd_r.count + 1'b1 : rd_r.count;
    if ({2'b0, m1_r} > {2'b0, rd_r.in_peak}) m.in_peak = m1_r;
    if (m2_r > rd_r.out_peak) m.out_peak = m2_r;
    m.in_sum  = cmm_pkg::sat_add(rd_r.in_sum, 64'(m1_r) * 64'(m1_r));
    m.out_sum = cmm_pkg::sat_add(rd_r.out_sum, 64'(m2_r) * 64'(m2_r));
    m.count = cnt1;
    wr_m = m;
    if (last_r) begin
      if (mval_nxt_f()) begin
        if (m.in_peak > rd_r.in_hold) wr_m.in_hold = m.in_peak;
        if (m.out_peak > rd_r.out_hold) wr_m.out_hold = m.out_peak;
      end
      wr_m.in_peak = '0; wr_m.out_peak = '0; wr_m.in_sum = '0;
      wr_m.out_sum = '0; wr_m.count = '0;
    end
    wr_en = (st_r == cmm_pkg::ST_MUL2);
    rreq.start = (st_r == cmm_pkg::ST_DIV);
    rreq.num = rms_sel_r ? out_sum_r : in_sum_r;
    rreq.den = n_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= cmm_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!clr_done_r) mem[clr_r[1:0]] <= '0;
    else if (wr_en) mem[ch_r] <= wr_m;
    rd_r <= mem[ch_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0; clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_r <= clr_r + 3'd1;
      if (32'(clr_r) == CHANNELS - 1) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      cmm_pkg::ST_IDLE: if (in_valid && in_ready) begin
        ch_r   <= in_chan;
        neg_r  <= in_sample_in[23];
        mag_r  <= in_sample_in[23] ? 24'(-in_sample_in) : in_sample_in;
        pres_r <= in_source_present;
        last_r <= in_last_frame;
        rms_sel_r <= 1'b0;
      end
      cmm_pkg::ST_READ: m1_r <= (active && pres_r) ? 26'(p1 >> 14) : '0;
      cmm_pkg::ST_MUL1: m2_r <= cfg.master_mute ? '0 : 28'(p2 >> 14);
      cmm_pkg::ST_MUL2: begin
        mval_r <= mval_nxt_f();
        in_sum_r <= m.in_sum; out_sum_r <= m.out_sum; n_r <= cnt1;
        o_ip_r <= m.in_peak; o_op_r <= m.out_peak;
        o_ih_r <= wr_m.in_hold; o_oh_r <= wr_m.out_hold;
      end
      cmm_pkg::ST_SQRT: if (rrsp.done) begin
        if (rms_sel_r) o_or_r <= rrsp.root[27:0];
        else           o_ir_r <= rrsp.root[25:0];
        rms_sel_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: loads a finished beat, or a bypass beat for channel numbers beyond CHANNELS.
  logic load_main, load_byp;
  assign load_main = (st_r == cmm_pkg::ST_DONE);
  assign load_byp  = (st_r == cmm_pkg::ST_IDLE) && in_valid && in_ready && !ch_ok;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (load_main || load_byp) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (load_byp) begin
      o_smp_r <= '0; o_ch_r <= in_chan; o_mv_r <= 1'b0;
    end else if (load_main) begin
      o_smp_r <= neg_r ? -$signed(m2_r) : $signed(m2_r);
      o_ch_r <= ch_r; o_mv_r <= mval_r;
    end
  end

  assign out_valid = ov_r;
  assign out_sample_out = o_smp_r;
  assign out_out_chan = o_ch_r;
  assign out_meter_valid = o_mv_r;
  assign out_in_peak  = o_mv_r ? o_ip_r : '0;
  assign out_in_rms   = o_mv_r ? o_ir_r : '0;
  assign out_in_hold  = o_mv_r ? o_ih_r : '0;
  assign out_out_peak = o_mv_r ? o_op_r : '0;
  assign out_out_rms  = o_mv_r ? o_or_r : '0;
  assign out_out_hold = o_mv_r ? o_oh_r : '0;
  assign out_in_overload  = o_mv_r && ({2'b0, o_ip_r} >= cmm_pkg::UNITY);
  assign out_out_overload = o_mv_r && (o_op_r >= cmm_pkg::UNITY);
endmodule

// ----- hw/rtl/channel_mixer_with_meters.sv -----
// Top level of the channel mixer with meters.
// Depends on cmm_pkg, cmm_cfg and cmm_core.
// One beat in gives one beat out. An ordinary sample passes through ST_READ, ST_MUL1
// and ST_MUL2 to ST_DONE, where it is loaded into the output register; no new beat is
// accepted before the sequencer is back in ST_IDLE. A channel's last frame that reports
// meters also runs the shared divide-and-square-root unit (64 divide steps, then 32 root
// steps), once for the input and once for the output RMS. The next beat is taken once the
// result register is free. After reset a pass over every channel's word clears the meter
// memory, and no beat is taken until it has finished.
module channel_mixer_with_meters #(
  parameter int unsigned CHANNELS   = cmm_pkg::CHANNELS_DEF,
  parameter int unsigned MAX_FRAMES = cmm_pkg::MAX_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [cmm_pkg::CIDX_W-1:0] cfg_index,
  input  logic [cmm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_chan,
  input  logic signed [23:0] in_sample_in,
  input  logic in_source_present,
  input  logic in_last_frame,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [27:0] out_sample_out,
  output logic [1:0] out_out_chan,
  output logic out_meter_valid,
  output logic [25:0] out_in_peak,
  output logic [25:0] out_in_rms,
  output logic [25:0] out_in_hold,
  output logic [27:0] out_out_peak,
  output logic [27:0] out_out_rms,
  output logic [27:0] out_out_hold,
  output logic out_in_overload,
  output logic out_out_overload
);
  cmm_pkg::cfg_t cfg;

  cmm_cfg u_cfg (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
                 .cfg_wdata(cfg_wdata), .cfg(cfg));

  cmm_core #(.CHANNELS(CHANNELS), .MAX_FRAMES(MAX_FRAMES)) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_chan(in_chan),
    .in_sample_in(in_sample_in), .in_source_present(in_source_present),
    .in_last_frame(in_last_frame), .out_valid(out_valid), .out_ready(out_ready),
    .out_sample_out(out_sample_out), .out_out_chan(out_out_chan),
    .out_meter_valid(out_meter_valid), .out_in_peak(out_in_peak),
    .out_in_rms(out_in_rms), .out_in_hold(out_in_hold), .out_out_peak(out_out_peak),
    .out_out_rms(out_out_rms), .out_out_hold(out_out_hold),
    .out_in_overload(out_in_overload), .out_out_overload(out_out_overload));
endmodule

// ----- hw/rtl/cmm_checks.sv -----
// Port-level checks for the channel mixer with meters, bound to the top level.
// Depends on the top level's ports only.
module cmm_checks (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_meter_valid,
  input logic [25:0] out_in_peak,
  input logic [25:0] out_in_hold,
  input logic [27:0] out_out_peak,
  input logic [27:0] out_out_hold
);
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_meter_valid |-> out_in_hold >= out_in_peak && out_out_hold >= out_out_peak)
    else $error("hold below block peak");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_meter_valid |-> out_in_peak == 26'd0 && out_out_peak == 28'd0)
    else $error("meters not zero without meter_valid");
endmodule

bind channel_mixer_with_meters cmm_checks u_cmm_checks (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_meter_valid(out_meter_valid),
  .out_in_peak(out_in_peak), .out_in_hold(out_in_hold),
  .out_out_peak(out_out_peak), .out_out_hold(out_out_hold));

// ----- dv/tb_channel_mixer_with_meters.sv -----
// Self-checking testbench for channel_mixer_with_meters: random and directed samples
// are checked against an in-bench mixer and meter predictor. Depends on cmm_pkg, cmm_if
// and the RTL of the block.
module tb_channel_mixer_with_meters;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         chan;
    logic signed [23:0] sample;
    logic               present;
    logic               last;
  } sample_beat_t;

  typedef struct packed {
    logic signed [27:0] sample;
    logic [1:0]         chan;
    logic               meter_valid;
    logic [25:0]        in_peak;
    logic [25:0]        in_rms;
    logic [25:0]        in_hold;
    logic [27:0]        out_peak;
    logic [27:0]        out_rms;
    logic [27:0]        out_hold;
    logic               in_ovl;
    logic               out_ovl;
  } mix_result_t;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned FULL_BLOCK = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cmm_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [cmm_pkg::CFG_W-1:0] cfg_wdata = '0;

  cmm_if #(.T(sample_beat_t)) in_ch (clk);
  cmm_if #(.T(mix_result_t))  out_ch (clk);

  always #5 clk = ~clk;

  channel_mixer_with_meters i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_chan(in_ch.data.chan), .in_sample_in(in_ch.data.sample),
    .in_source_present(in_ch.data.present), .in_last_frame(in_ch.data.last),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sample_out(out_ch.data.sample), .out_out_chan(out_ch.data.chan),
    .out_meter_valid(out_ch.data.meter_valid),
    .out_in_peak(out_ch.data.in_peak), .out_in_rms(out_ch.data.in_rms),
    .out_in_hold(out_ch.data.in_hold), .out_out_peak(out_ch.data.out_peak),
    .out_out_rms(out_ch.data.out_rms), .out_out_hold(out_ch.data.out_hold),
    .out_in_overload(out_ch.data.in_ovl), .out_out_overload(out_ch.data.out_ovl)
  );

  // Predictor copy of the registers and per-channel meter state.
  cmm_pkg::cfg_t mix_cfg;
  logic [25:0] in_pk [4];
  logic [27:0] out_pk [4];
  logic [63:0] in_sq [4];
  logic [63:0] out_sq [4];
  logic [25:0] in_hold_q [4];
  logic [27:0] out_hold_q [4];
  int unsigned frames [4];

  sample_beat_t pend_q[$];
  mix_result_t  mix_expect_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  bit           calm = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  sink_stall = 0;

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] apply_gain(input logic [63:0] mag, input logic [15:0] g);
    return (mag * g + 64'd8192) >> 14;
  endfunction

  function automatic mix_result_t mix_predict(input sample_beat_t b);
    mix_result_t r;
    int unsigned c;
    logic        neg;
    logic [63:0] mag, m1, m2, rms;
    logic [15:0] cg, mg;
    logic        active;
    r = '0;
    c = 32'(b.chan);
    r.chan = b.chan;
    neg = b.sample[23];
    mag = neg ? 64'h1000000 - {40'd0, b.sample} : {40'd0, b.sample};
    cg = mix_cfg.chan_gains[16*c +: 16];
    active = !mix_cfg.mute[c] && (mix_cfg.solo == 0 || mix_cfg.solo[c]);
    m1 = (active && b.present) ? apply_gain(mag, cg) : 64'd0;
    mg = (c == 0) ? mix_cfg.left_gain : (c == 1) ? mix_cfg.right_gain : mix_cfg.fader_gain;
    m2 = mix_cfg.master_mute ? 64'd0 : apply_gain(m1, mg);
    r.sample = neg ? -m2[27:0] : m2[27:0];
    if (m1 > in_pk[c]) in_pk[c] = m1[25:0];
    if (m2 > out_pk[c]) out_pk[c] = m2[27:0];
    in_sq[c] = add_sat(in_sq[c], m1 * m1);
    out_sq[c] = add_sat(out_sq[c], m2 * m2);
    if (frames[c] <= cmm_pkg::MAX_FRAMES_DEF) frames[c]++;
    if (b.last) begin
      // An overlong block still clears its accumulators but reports nothing.
      if (frames[c] >= 1 && frames[c] <= cmm_pkg::MAX_FRAMES_DEF) begin
        if (in_pk[c] > in_hold_q[c]) in_hold_q[c] = in_pk[c];
        if (out_pk[c] > out_hold_q[c]) out_hold_q[c] = out_pk[c];
        r.meter_valid = 1'b1;
        r.in_peak = in_pk[c];
        rms = root64(in_sq[c] / frames[c]);
        r.in_rms = rms[25:0];
        r.in_hold = in_hold_q[c];
        r.out_peak = out_pk[c];
        rms = root64(out_sq[c] / frames[c]);
        r.out_rms = rms[27:0];
        r.out_hold = out_hold_q[c];
        r.in_ovl = in_pk[c] >= 26'h800000;
        r.out_ovl = out_pk[c] >= 28'h800000;
      end
      in_pk[c] = '0;
      out_pk[c] = '0;
      in_sq[c] = '0;
      out_sq[c] = '0;
      frames[c] = 0;
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        in_ch.data <= pend_q.pop_front();
        in_ch.valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      sink_stall <= pick_gap();
    end
  end

  // Monitor: predict on every accepted input beat, check every accepted result beat.
  always @(posedge clk) begin
    mix_result_t w;
    mix_result_t g;
    if (rst_n && in_ch.valid && in_ch.ready) mix_expect_q.push_back(mix_predict(in_ch.data));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (mix_expect_q.size() == 0) begin
        $display("[%0t] result beat with nothing expected", $realtime);
        errors++;
      end else begin
        w = mix_expect_q.pop_front();
        if (g.sample !== w.sample)
          report("sample_out", 64'(g.sample), 64'(w.sample));
        if (g.chan !== w.chan) report("out_chan", 64'(g.chan), 64'(w.chan));
        if (g.meter_valid !== w.meter_valid)
          report("meter_valid", 64'(g.meter_valid), 64'(w.meter_valid));
        if (g.in_peak !== w.in_peak) report("in_peak", 64'(g.in_peak), 64'(w.in_peak));
        if (g.in_rms !== w.in_rms) report("in_rms", 64'(g.in_rms), 64'(w.in_rms));
        if (g.in_hold !== w.in_hold) report("in_hold", 64'(g.in_hold), 64'(w.in_hold));
        if (g.out_peak !== w.out_peak)
          report("out_peak", 64'(g.out_peak), 64'(w.out_peak));
        if (g.out_rms !== w.out_rms) report("out_rms", 64'(g.out_rms), 64'(w.out_rms));
        if (g.out_hold !== w.out_hold)
          report("out_hold", 64'(g.out_hold), 64'(w.out_hold));
        if (g.in_ovl !== w.in_ovl) report("in_overload", 64'(g.in_ovl), 64'(w.in_ovl));
        if (g.out_ovl !== w.out_ovl)
          report("out_overload", 64'(g.out_ovl), 64'(w.out_ovl));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("channel_mixer_with_meters test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [cmm_pkg::CIDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cmm_pkg::REG_LEFT_GAIN:   mix_cfg.left_gain = val[15:0];
      cmm_pkg::REG_RIGHT_GAIN:  mix_cfg.right_gain = val[15:0];
      cmm_pkg::REG_FADER_GAIN:  mix_cfg.fader_gain = val[15:0];
      cmm_pkg::REG_CHAN_GAINS:  mix_cfg.chan_gains = val;
      cmm_pkg::REG_MUTE_MASK:   mix_cfg.mute = val[3:0];
      cmm_pkg::REG_SOLO_MASK:   mix_cfg.solo = val[3:0];
      cmm_pkg::REG_MASTER_MUTE: mix_cfg.master_mute = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mixer(input logic [15:0] lg, input logic [15:0] rg, input logic [15:0] fg,
                           input logic [63:0] cg, input logic [3:0] mu, input logic [3:0] so,
                           input logic mm);
    write_reg(cmm_pkg::REG_LEFT_GAIN, 64'(lg));
    write_reg(cmm_pkg::REG_RIGHT_GAIN, 64'(rg));
    write_reg(cmm_pkg::REG_FADER_GAIN, 64'(fg));
    write_reg(cmm_pkg::REG_CHAN_GAINS, cg);
    write_reg(cmm_pkg::REG_MUTE_MASK, 64'(mu));
    write_reg(cmm_pkg::REG_SOLO_MASK, 64'(so));
    write_reg(cmm_pkg::REG_MASTER_MUTE, 64'(mm));
  endtask

  // The sender holds off here until every expected beat has come back.
  task automatic drain();
    while (pend_q.size() > 0 || in_ch.valid || mix_expect_q.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic sample_beat_t make_beat(input logic [1:0] ch, input logic [23:0] s,
                                             input logic pr, input logic la);
    sample_beat_t b;
    b.chan = ch;
    b.sample = s;
    b.present = pr;
    b.last = la;
    return b;
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 31) - 16);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_items(input int unsigned count);
    repeat (count) begin
      pend_q.push_back(make_beat(2'($urandom_range(0, 3)), rand_sample(),
                                 $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0));
    end
  endtask

  task automatic random_mixer(input logic [3:0] mu, input logic [3:0] so);
    set_mixer(16'($urandom), 16'($urandom), 16'($urandom), {$urandom, $urandom}, mu, so,
              1'b0);
  endtask

  initial begin
    logic [23:0] edge_s [5];
    edge_s = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001};
    mix_cfg = '{cmm_pkg::LEFT_GAIN_RST, cmm_pkg::LEFT_GAIN_RST, cmm_pkg::FADER_GAIN_RST,
                cmm_pkg::CHAN_GAINS_RST, 4'h0, 4'h0, 1'b0};
    for (int c = 0; c < 4; c++) begin
      in_pk[c] = '0; out_pk[c] = '0; in_sq[c] = '0; out_sq[c] = '0;
      in_hold_q[c] = '0; out_hold_q[c] = '0; frames[c] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: field extremes, an absent source and one block per channel.
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 5; k++) pend_q.push_back(make_beat(2'(c), edge_s[k], 1'b1, 1'b0));
      pend_q.push_back(make_beat(2'(c), 24'h7FFFFF, 1'b0, 1'b1));
    end
    random_items(100);
    drain();

    // Largest gains, with full-scale blocks on two channels.
    set_mixer(16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 4'h0, 4'h0, 1'b0);
    calm = 1'b1;
    for (int k = 0; k < FULL_BLOCK; k++)
      pend_q.push_back(make_beat(2'd2, k[0] ? 24'h800000 : 24'h7FFFFF, 1'b1,
                                 k == FULL_BLOCK - 1));
    for (int k = 0; k <= FULL_BLOCK; k++)
      pend_q.push_back(make_beat(2'd3, 24'h7FFFFF, 1'b1, k == FULL_BLOCK));
    random_items(80);
    drain();
    calm = 1'b0;

    set_mixer(16'h0000, 16'h0000, 16'h0000, '0, 4'h0, 4'h0, 1'b0);
    random_items(90);
    drain();

    random_mixer(4'b0101, 4'h0);
    random_items(100);
    drain();

    random_mixer(4'b0010, 4'b0011);
    random_items(100);
    drain();

    set_mixer(16'd11585, 16'd11585, 16'd16384, cmm_pkg::CHAN_GAINS_RST, 4'h0, 4'h0, 1'b1);
    random_items(90);
    drain();

    for (int p = 0; p < 3; p++) begin
      random_mixer(4'($urandom), 4'($urandom));
      random_items(80);
      drain();
    end

    if (errors == 0) begin
      $display("channel_mixer_with_meters test passed");
    end else begin
      $display("channel_mixer_with_meters test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/cmm_pkg.sv
hw/rtl/cmm_if.sv
hw/rtl/cmm_cfg.sv
hw/rtl/cmm_root.sv
hw/rtl/cmm_core.sv
hw/rtl/channel_mixer_with_meters.sv
hw/rtl/cmm_checks.sv
dv/tb_channel_mixer_with_meters.sv
